### sv/gbcc_pkg.sv
// Shared types and constants for the grain bitmap cross-checker.
// Used by gbcc_ctrl, gbcc_dp and grain_bitmap_cross_checker_core; no dependencies.
package gbcc_pkg;

    localparam int unsigned DEF_MAX_GRAINS = 65536;

    localparam int unsigned GRAIN_W = 32;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned CNT_W   = 17;
    localparam int unsigned IDX_W   = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_REF   = 2'd0,
        MODE_MARK  = 2'd1,
        MODE_CHECK = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_HOLE  = 2'd1,
        ST_RANGE = 2'd2,
        ST_TWICE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RD_INPUT = 2'd0,
        RD_GRAIN = 2'd1,
        RD_SCAN  = 2'd2
    } t_rd_sel;

    typedef struct packed {
        t_rd_sel rd_sel;
        logic    accept;
        logic    clear;
        logic    scan_step;
        logic    update;
        logic    load_scan;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic in_check;
        logic scan_done;
    } t_sts;

endpackage

### sv/grain_bitmap_cross_checker_core.sv
// Grain bitmap cross-checker top level: gbcc_ctrl sequencer plus gbcc_dp datapath.
// Reference and mark words: read on accept, then written back in the update state, which also registers the result.
// Check word: scans min(grain_count, MAX_GRAINS) grains, one grain read per cycle, and registers the result
// in the result state. No word is taken until the one before is through; a held result stalls the next word.
// After reset a clearing pass zeroes all MAX_GRAINS memory entries; no word is taken
// meanwhile, configuration writes are. grain_count resets to 0.
module grain_bitmap_cross_checker_core #(
    parameter int unsigned MAX_GRAINS = gbcc_pkg::DEF_MAX_GRAINS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gbcc_pkg::CNT_W-1:0]    i_cfg_grain_count,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [gbcc_pkg::MODE_W-1:0]   i_mode,
    input  logic [gbcc_pkg::GRAIN_W-1:0]  i_grain,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [gbcc_pkg::STAT_W-1:0]   o_status,
    output logic [gbcc_pkg::CNT_W-1:0]    o_referenced_total,
    output logic [gbcc_pkg::CNT_W-1:0]    o_marked_total,
    output logic [gbcc_pkg::CNT_W-1:0]    o_free_total,
    output logic [gbcc_pkg::CNT_W-1:0]    o_phantom_total,
    output logic [gbcc_pkg::CNT_W-1:0]    o_leaked_total,
    output logic [gbcc_pkg::IDX_W-1:0]    o_first_phantom,
    output logic [gbcc_pkg::IDX_W-1:0]    o_first_leaked,
    output logic                          o_reserved_unmarked
);
    import gbcc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    gbcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    gbcc_dp #(
        .MAX_GRAINS (MAX_GRAINS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_grain_count   (i_cfg_grain_count),
        .i_mode              (i_mode),
        .i_grain             (i_grain),
        .o_status            (o_status),
        .o_referenced_total  (o_referenced_total),
        .o_marked_total      (o_marked_total),
        .o_free_total        (o_free_total),
        .o_phantom_total     (o_phantom_total),
        .o_leaked_total      (o_leaked_total),
        .o_first_phantom     (o_first_phantom),
        .o_first_leaked      (o_first_leaked),
        .o_reserved_unmarked (o_reserved_unmarked)
    );

endmodule

### sv/gbcc_ctrl.sv
// Sequencing controller: clearing pass, word accept, update, scan and result hand-off.
// Depends on gbcc_pkg for the command and status structs.
module gbcc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  gbcc_pkg::t_sts  i_sts,
    output gbcc_pkg::t_cmd  o_cmd
);
    import gbcc_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE,
        S_SCAN,
        S_RESULT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.rd_sel = RD_GRAIN;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.rd_sel = RD_INPUT;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_sts.in_check ? S_SCAN : S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (slot_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.rd_sel    = RD_SCAN;
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (slot_free) begin
                    o_cmd.load_scan = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.update || o_cmd.load_scan) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### sv/gbcc_dp.sv
// Datapath: grain bit memory, count register, scan counters and result registers.
// Depends on gbcc_pkg; driven by gbcc_ctrl commands.
module gbcc_dp #(
    parameter int unsigned MAX_GRAINS = gbcc_pkg::DEF_MAX_GRAINS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gbcc_pkg::t_cmd                i_cmd,
    output gbcc_pkg::t_sts                o_sts,
    input  logic                          i_cfg_valid,
    input  logic [gbcc_pkg::CNT_W-1:0]    i_cfg_grain_count,
    input  logic [gbcc_pkg::MODE_W-1:0]   i_mode,
    input  logic [gbcc_pkg::GRAIN_W-1:0]  i_grain,
    output logic [gbcc_pkg::STAT_W-1:0]   o_status,
    output logic [gbcc_pkg::CNT_W-1:0]    o_referenced_total,
    output logic [gbcc_pkg::CNT_W-1:0]    o_marked_total,
    output logic [gbcc_pkg::CNT_W-1:0]    o_free_total,
    output logic [gbcc_pkg::CNT_W-1:0]    o_phantom_total,
    output logic [gbcc_pkg::CNT_W-1:0]    o_leaked_total,
    output logic [gbcc_pkg::IDX_W-1:0]    o_first_phantom,
    output logic [gbcc_pkg::IDX_W-1:0]    o_first_leaked,
    output logic                          o_reserved_unmarked
);
    import gbcc_pkg::*;

    localparam int unsigned AW = (MAX_GRAINS > 1) ? $clog2(MAX_GRAINS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_GRAINS - 1);
    localparam logic [31:0]   MAX_W     = 32'(MAX_GRAINS);

    // bit 1 allocated, bit 0 referenced
    logic [1:0]          r_mem [MAX_GRAINS];
    logic [1:0]          r_rdata;
    logic [AW-1:0]       raddr, waddr;
    logic [1:0]          wdata;
    logic                we;

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    live;
    t_mode               r_mode;
    logic [GRAIN_W-1:0]  r_grain;
    logic [AW-1:0]       r_clr;
    logic [CNT_W-1:0]    r_idx, r_sidx;
    logic                r_sv;
    logic [31:0]         idx_ext;
    logic                scan_done;

    logic [CNT_W-1:0]    r_nref, r_nmark, r_nfree, r_nph, r_nleak;
    logic [IDX_W-1:0]    r_fph, r_fleak, sidx_clamp;
    logic                r_res0;

    logic                u_bit, a_bit, is_ph, is_leak;
    logic                oor;
    t_status             upd_status;
    logic                upd_write;
    logic [1:0]          upd_data;

    logic [STAT_W-1:0]   r_status;
    logic [CNT_W-1:0]    r_o_ref, r_o_mark, r_o_free, r_o_ph, r_o_leak;
    logic [IDX_W-1:0]    r_o_fph, r_o_fleak;
    logic                r_o_res;

    assign live      = (32'(r_count) > MAX_W) ? MAX_W[CNT_W-1:0] : r_count;
    assign scan_done = (r_idx >= live);
    assign idx_ext   = 32'(r_idx);

    assign o_sts.clear_last = (r_clr == LAST_ADDR);
    assign o_sts.in_check   = (t_mode'(i_mode) == MODE_CHECK);
    assign o_sts.scan_done  = scan_done;

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_INPUT: raddr = i_grain[AW-1:0];
            RD_SCAN:  raddr = idx_ext[AW-1:0];
            default:  raddr = r_grain[AW-1:0];
        endcase
    end

    // update decision for reference and mark words
    always_comb begin
        oor        = (r_grain >= 32'(live));
        upd_status = ST_OK;
        upd_write  = 1'b0;
        upd_data   = r_rdata;
        unique case (r_mode)
            MODE_REF: begin
                if (r_grain == '0) begin
                    upd_status = ST_HOLE;
                end else if (oor) begin
                    upd_status = ST_RANGE;
                end else begin
                    upd_status = r_rdata[0] ? ST_TWICE : ST_OK;
                    upd_write  = 1'b1;
                    upd_data   = r_rdata | 2'b01;
                end
            end
            MODE_MARK: begin
                if (oor) begin
                    upd_status = ST_RANGE;
                end else begin
                    upd_write = 1'b1;
                    upd_data  = r_rdata | 2'b10;
                end
            end
            MODE_CHECK, MODE_NONE: begin
                upd_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        if (i_cmd.clear) begin
            we    = 1'b1;
            waddr = r_clr;
            wdata = 2'b00;
        end else begin
            we    = i_cmd.update && upd_write;
            waddr = r_grain[AW-1:0];
            wdata = upd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_clr   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_count <= i_cfg_grain_count;
            end
            if (i_cmd.clear) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    assign u_bit      = r_rdata[0];
    assign a_bit      = r_rdata[1];
    assign is_ph      = u_bit && !a_bit;
    assign is_leak    = !u_bit && a_bit && (r_sidx != '0);
    assign sidx_clamp = r_sidx[CNT_W-1] ? '1 : r_sidx[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else if (i_cmd.accept) begin
            r_sv <= 1'b0;
        end else begin
            r_sv <= i_cmd.scan_step && !scan_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode  <= t_mode'(i_mode);
            r_grain <= i_grain;
            r_idx   <= '0;
            r_nref  <= '0;
            r_nmark <= '0;
            r_nfree <= '0;
            r_nph   <= '0;
            r_nleak <= '0;
            r_fph   <= '0;
            r_fleak <= '0;
            r_res0  <= 1'b0;
        end else begin
            if (i_cmd.scan_step && !scan_done) begin
                r_idx  <= r_idx + 1'b1;
            end
            r_sidx <= r_idx;
            if (r_sv) begin
                r_nref  <= r_nref + CNT_W'(u_bit);
                r_nmark <= r_nmark + CNT_W'(a_bit);
                r_nfree <= r_nfree + CNT_W'(!a_bit);
                if (is_ph) begin
                    if (r_nph == '0) begin
                        r_fph <= sidx_clamp;
                    end
                    r_nph <= r_nph + 1'b1;
                end else if (is_leak) begin
                    if (r_nleak == '0) begin
                        r_fleak <= sidx_clamp;
                    end
                    r_nleak <= r_nleak + 1'b1;
                end
                if (r_sidx == '0) begin
                    r_res0 <= !a_bit;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_status  <= upd_status;
            r_o_ref   <= '0;
            r_o_mark  <= '0;
            r_o_free  <= '0;
            r_o_ph    <= '0;
            r_o_leak  <= '0;
            r_o_fph   <= '0;
            r_o_fleak <= '0;
            r_o_res   <= 1'b0;
        end else if (i_cmd.load_scan) begin
            r_status  <= ST_OK;
            r_o_ref   <= r_nref;
            r_o_mark  <= r_nmark;
            r_o_free  <= r_nfree;
            r_o_ph    <= r_nph;
            r_o_leak  <= r_nleak;
            r_o_fph   <= r_fph;
            r_o_fleak <= r_fleak;
            r_o_res   <= r_res0;
        end
    end

    assign o_status            = r_status;
    assign o_referenced_total  = r_o_ref;
    assign o_marked_total      = r_o_mark;
    assign o_free_total        = r_o_free;
    assign o_phantom_total     = r_o_ph;
    assign o_leaked_total      = r_o_leak;
    assign o_first_phantom     = r_o_fph;
    assign o_first_leaked      = r_o_fleak;
    assign o_reserved_unmarked = r_o_res;

endmodule
